>>> hdl/prfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the polynomial-from-roots block.
// No dependencies; every other file refers to it by scoped names.
package prfr_pkg;

  localparam int DataW   = 32;
  localparam int IdxW    = 6;
  localparam int StepW   = $clog2(DataW);
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_MODULUS   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_NULL_ROOT = 1'd1;

  localparam logic [DataW-1:0] MOD_RESET = 32'd65537;

  typedef enum logic [1:0] {
    RED_IDLE,
    RED_RUN,
    RED_FIN,
    RED_HOLD
  } red_state_e;

  typedef enum logic [1:0] {
    CH_IDLE,
    CH_STEP,
    CH_EMIT
  } chain_state_e;

  typedef struct packed {
    logic step;
    logic first;
    logic last;
    logic clr;
    logic shift;
  } prfr_ctrl_t;

endpackage

>>> hdl/prfr_in_if.sv
`timescale 1ns / 1ps
// Input channel of the polynomial-from-roots block: one slot per transfer.
// Depends on prfr_pkg for the field widths.
interface prfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [prfr_pkg::DataW-1:0] root_value;
  logic                       slot_filled;

  modport source (output valid, root_value, slot_filled, input ready);
  modport sink (input valid, root_value, slot_filled, output ready);
endinterface

>>> hdl/prfr_out_if.sv
`timescale 1ns / 1ps
// Output channel of the polynomial-from-roots block: one coefficient per transfer.
// Depends on prfr_pkg for the field widths.
interface prfr_out_if;
  logic                       valid;
  logic                       ready;
  logic [prfr_pkg::IdxW-1:0]  coeff_index;
  logic [prfr_pkg::DataW-1:0] coeff_value;
  logic                       last_coeff;

  modport source (output valid, coeff_index, coeff_value, last_coeff, input ready);
  modport sink (input valid, coeff_index, coeff_value, last_coeff, output ready);
endinterface

>>> hdl/prfr_reduce.sv
`timescale 1ns / 1ps
// Front stage: reduces one slot's value modulo the modulus, one bit per cycle,
// and negates it for a filled slot to form the negated root. Depends on prfr_pkg.
module prfr_reduce (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [prfr_pkg::DataW-1:0] root_i,
  input  logic                       filled_i,
  input  logic [prfr_pkg::DataW-1:0] null_root_i,
  input  logic [prfr_pkg::DataW:0]   mod_i,
  output logic                       t_valid_o,
  output logic [prfr_pkg::DataW-1:0] t_o,
  input  logic                       take_i
);

  prfr_pkg::red_state_e              state_q, state_d;
  logic [prfr_pkg::StepW-1:0]        cnt_q, cnt_d;
  logic [prfr_pkg::DataW-1:0]        x_q, x_d;
  logic [prfr_pkg::DataW-1:0]        acc_q, acc_d;
  logic                              filled_q, filled_d;
  logic [prfr_pkg::DataW:0]          dbl, red, neg;

  assign dbl = {acc_q, x_q[prfr_pkg::DataW-1]};
  assign red = (dbl >= mod_i) ? dbl - mod_i : dbl;
  assign neg = mod_i - {1'b0, acc_q};
  assign t_o = acc_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    x_d        = x_q;
    acc_d      = acc_q;
    filled_d   = filled_q;
    in_ready_o = 1'b0;
    t_valid_o  = 1'b0;
    unique case (state_q)
      prfr_pkg::RED_IDLE: begin
        in_ready_o = 1'b1;
      end
      prfr_pkg::RED_RUN: begin
        // horner step: acc = 2*acc + next bit, kept below the modulus
        acc_d = red[prfr_pkg::DataW-1:0];
        x_d   = x_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == prfr_pkg::StepW'(prfr_pkg::DataW - 1)) begin
          state_d = prfr_pkg::RED_FIN;
        end
      end
      prfr_pkg::RED_FIN: begin
        if (filled_q && acc_q != '0) begin
          acc_d = neg[prfr_pkg::DataW-1:0];
        end
        state_d = prfr_pkg::RED_HOLD;
      end
      prfr_pkg::RED_HOLD: begin
        t_valid_o = 1'b1;
        if (take_i) begin
          in_ready_o = 1'b1;
          state_d    = prfr_pkg::RED_IDLE;
        end
      end
      default: begin
        state_d = prfr_pkg::RED_IDLE;
      end
    endcase
    if (in_valid_i && in_ready_o) begin
      x_d      = filled_i ? root_i : null_root_i;
      filled_d = filled_i;
      acc_d    = '0;
      cnt_d    = '0;
      state_d  = prfr_pkg::RED_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prfr_pkg::RED_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    acc_q    <= acc_d;
    filled_q <= filled_d;
  end

endmodule

>>> hdl/prfr_cell.sv
`timescale 1ns / 1ps
// One cell of the coefficient chain: holds a coefficient and folds in
// t times its upper neighbor, one bit per cycle. Depends on prfr_pkg.
module prfr_cell (
  input  logic                       clk_i,
  input  prfr_pkg::prfr_ctrl_t       ctrl_i,
  input  logic [prfr_pkg::DataW-1:0] t_i,
  input  logic [prfr_pkg::DataW:0]   mod_i,
  input  logic                       nb_bit_i,
  input  logic [prfr_pkg::DataW-1:0] nb_word_i,
  output logic                       msb_o,
  output logic [prfr_pkg::DataW-1:0] coef_o
);

  logic [prfr_pkg::DataW-1:0] acc_q, acc_d, coef_q, coef_d, acc_prev;
  logic                       c_bit;
  logic [prfr_pkg::DataW+1:0] sum, mod_x, mod2_x, sub1, sub2;

  assign acc_prev = ctrl_i.first ? '0 : acc_q;
  // at row start the stored words are stale, read them as zero
  assign c_bit    = coef_q[prfr_pkg::DataW-1] & ~ctrl_i.clr;
  assign mod_x    = {1'b0, mod_i};
  assign mod2_x   = {mod_i, 1'b0};
  // acc < m, t < m: 2*acc + t + 1 stays below 3*m
  assign sum      = {1'b0, acc_prev, 1'b0} + (nb_bit_i ? {2'b00, t_i} : '0)
                  + {{(prfr_pkg::DataW + 1){1'b0}}, c_bit};
  assign sub1     = sum - mod_x;
  assign sub2     = sum - mod2_x;

  always_comb begin
    priority if (sum >= mod2_x) begin
      acc_d = sub2[prfr_pkg::DataW-1:0];
    end else if (sum >= mod_x) begin
      acc_d = sub1[prfr_pkg::DataW-1:0];
    end else begin
      acc_d = sum[prfr_pkg::DataW-1:0];
    end
  end

  always_comb begin
    priority if (ctrl_i.shift) begin
      coef_d = nb_word_i;
    end else if (ctrl_i.step) begin
      coef_d = ctrl_i.last ? acc_d
                           : {coef_q[prfr_pkg::DataW-2:0], coef_q[prfr_pkg::DataW-1]};
    end else begin
      coef_d = coef_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      acc_q <= acc_d;
    end
    coef_q <= coef_d;
  end

  assign msb_o  = coef_q[prfr_pkg::DataW-1];
  assign coef_o = coef_q;

endmodule

>>> hdl/poly_from_roots_mod.sv
`timescale 1ns / 1ps
// Top level: builds prod (y - r) modulo a configured modulus over a row of SLOTS slots.
// Depends on prfr_pkg, prfr_in_if, prfr_out_if, prfr_reduce and prfr_cell.
//
// Usage:
//   in_if carries one slot per transfer (root_value, slot_filled); an empty slot
//   uses the configured negated null root. out_if carries the SLOTS+1 coefficients
//   of a row, degree 0 first, last_coeff set on the leading one.
//   Registers (index 0 the modulus, 0 meaning 2^32; index 1 the negated null root) are
//   written via cfg_we_i/cfg_index_i/cfg_data_i; the user keeps to idle, unenforced.
// Timing:
//   A front unit reduces the root modulo the modulus one bit per cycle (32 steps plus
//   negation), overlapped with the previous slot in the cell chain, where every
//   coefficient cell does a 32-step bit-serial multiply-add at once. Valid rises once
//   the last slot of a row has been reduced and stepped through the chain, then one
//   coefficient transfers per cycle while out_if is ready; a stall simply holds the
//   chain. The next row's first slot is reduced while the last one is in the chain.
// Reset: control state clears, the modulus returns to 65537 and the null root to 0.
module poly_from_roots_mod #(
  parameter int SLOTS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  prfr_in_if.sink                      in_if,
  prfr_out_if.source                   out_if,
  input  logic                         cfg_we_i,
  input  logic [prfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [prfr_pkg::DataW-1:0]   cfg_data_i
);

  logic [prfr_pkg::DataW-1:0] modulus_q, null_root_q;
  logic [prfr_pkg::DataW:0]   mod_eff;
  logic [prfr_pkg::DataW-1:0] one_mod;

  prfr_pkg::chain_state_e     ch_state_q, ch_state_d;
  logic [prfr_pkg::IdxW-1:0]  slot_q, slot_d;
  logic [prfr_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [prfr_pkg::StepW-1:0] step_q, step_d;
  logic [prfr_pkg::DataW-1:0] t_q, t_d;
  logic [prfr_pkg::DataW-1:0] top_q, top_d;
  logic                       clr_q, clr_d;

  logic                       take;
  logic                       out_valid;
  logic                       red_t_valid;
  logic                       red_ready;
  logic [prfr_pkg::DataW-1:0] red_t;
  prfr_pkg::prfr_ctrl_t       ctrl;

  logic [prfr_pkg::DataW-1:0] coef [SLOTS];
  logic                       msb [SLOTS];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= prfr_pkg::MOD_RESET;
      null_root_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        prfr_pkg::CFG_MODULUS:   modulus_q   <= cfg_data_i;
        prfr_pkg::CFG_NULL_ROOT: null_root_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign mod_eff = {modulus_q == '0, modulus_q};
  assign one_mod = {{(prfr_pkg::DataW - 1){1'b0}}, modulus_q != prfr_pkg::DataW'(1)};

  prfr_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (red_ready),
    .root_i      (in_if.root_value),
    .filled_i    (in_if.slot_filled),
    .null_root_i (null_root_q),
    .mod_i       (mod_eff),
    .t_valid_o   (red_t_valid),
    .t_o         (red_t),
    .take_i      (take)
  );

  assign in_if.ready = red_ready;

  // chain sequencer
  always_comb begin
    ch_state_d = ch_state_q;
    slot_d     = slot_q;
    idx_d      = idx_q;
    step_d     = step_q;
    t_d        = t_q;
    top_d      = top_q;
    clr_d      = clr_q;
    take       = 1'b0;
    out_valid  = 1'b0;
    ctrl       = '0;
    unique case (ch_state_q)
      prfr_pkg::CH_IDLE: begin
        if (red_t_valid) begin
          take       = 1'b1;
          t_d        = red_t;
          clr_d      = (slot_q == '0);
          if (slot_q == '0) begin
            top_d = one_mod;
          end
          step_d     = '0;
          ch_state_d = prfr_pkg::CH_STEP;
        end
      end
      prfr_pkg::CH_STEP: begin
        ctrl.step  = 1'b1;
        ctrl.clr   = clr_q;
        ctrl.first = (step_q == '0);
        ctrl.last  = (step_q == prfr_pkg::StepW'(prfr_pkg::DataW - 1));
        // leading coefficient rotates with the others and is back in place at the end
        top_d      = {top_q[prfr_pkg::DataW-2:0], top_q[prfr_pkg::DataW-1]};
        step_d     = step_q + 1'b1;
        if (ctrl.last) begin
          if (slot_q == prfr_pkg::IdxW'(SLOTS - 1)) begin
            slot_d     = '0;
            idx_d      = '0;
            ch_state_d = prfr_pkg::CH_EMIT;
          end else begin
            slot_d     = slot_q + 1'b1;
            ch_state_d = prfr_pkg::CH_IDLE;
          end
        end
      end
      prfr_pkg::CH_EMIT: begin
        out_valid = 1'b1;
        if (out_if.ready) begin
          ctrl.shift = 1'b1;
          top_d      = '0;
          idx_d      = idx_q + 1'b1;
          if (idx_q == prfr_pkg::IdxW'(SLOTS)) begin
            ch_state_d = prfr_pkg::CH_IDLE;
          end
        end
      end
      default: begin
        ch_state_d = prfr_pkg::CH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_state_q <= prfr_pkg::CH_IDLE;
      slot_q     <= '0;
      idx_q      <= '0;
      step_q     <= '0;
      clr_q      <= 1'b0;
    end else begin
      ch_state_q <= ch_state_d;
      slot_q     <= slot_d;
      idx_q      <= idx_d;
      step_q     <= step_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    top_q <= top_d;
  end

  // cell k holds the coefficient of degree k; the leading one sits in top_q
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic                       nb_bit;
    logic [prfr_pkg::DataW-1:0] nb_word;
    if (k == SLOTS - 1) begin : g_upper
      assign nb_bit  = top_q[prfr_pkg::DataW-1];
      assign nb_word = top_q;
    end else begin : g_inner
      assign nb_bit  = msb[k+1] & ~clr_q;
      assign nb_word = coef[k+1];
    end
    prfr_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .t_i       (t_q),
      .mod_i     (mod_eff),
      .nb_bit_i  (nb_bit),
      .nb_word_i (nb_word),
      .msb_o     (msb[k]),
      .coef_o    (coef[k])
    );
  end

  assign out_if.valid       = out_valid;
  assign out_if.coeff_index = idx_q;
  assign out_if.coeff_value = coef[0];
  assign out_if.last_coeff  = (idx_q == prfr_pkg::IdxW'(SLOTS));

`ifndef SYNTH
  a_t_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_state_q == prfr_pkg::CH_STEP |-> {1'b0, t_q} < mod_eff)
    else $error("negated root not below modulus");

  a_row_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_state_q == prfr_pkg::CH_STEP && step_q == prfr_pkg::StepW'(prfr_pkg::DataW - 1)
      && slot_q == prfr_pkg::IdxW'(SLOTS - 1)
      |=> ch_state_q == prfr_pkg::CH_EMIT && idx_q == '0)
    else $error("row did not start output after its last slot");

  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && out_if.last_coeff |=> !out_if.valid && slot_q == '0)
    else $error("output continued past the leading coefficient");

  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && slot_q == '0 |=> clr_q && top_q == one_mod)
    else $error("row start did not seed the leading coefficient");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < prfr_pkg::IdxW'(SLOTS))
    else $error("slot count out of range");
`endif

endmodule
